// ===== design/kdj_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// KDJ package
// Shared widths, register indexes and controller command/status types.
// ----------------------------------------------------------------------------
package kdj_pkg;

    localparam int unsigned Q_BITS     = 23;
    localparam int unsigned J_BITS     = 26;
    localparam int unsigned IDX_BITS   = 2;
    localparam int unsigned DIV_BITS   = 23;
    localparam logic [22:0] Q_HUNDRED  = 23'd6553600;
    localparam logic [22:0] Q_FIFTY    = 23'd3276800;
    // reciprocal of three scaled by 2^25, rounded up
    localparam logic [23:0] DIV3_MUL   = 24'd11184811;

    typedef enum logic [IDX_BITS-1:0] {
        REG_K_START = 2'd0,
        REG_D_START = 2'd1,
        REG_GAP_THR = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic scan;
        logic div_start;
        logic div_step;
        logic k_calc;
        logic d_calc;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_done;
    } t_status;

endpackage : kdj_pkg
`default_nettype wire

// ===== design/kdj_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// KDJ channel interfaces
// Valid/ready channels for bars, results and register writes.
// ----------------------------------------------------------------------------
interface kdj_bar_if #(parameter int unsigned PRICE_BITS = 24);
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] bar_high;
    logic [PRICE_BITS-1:0] bar_low;
    logic [PRICE_BITS-1:0] bar_price;
    logic                  is_close;
    modport source (output valid, bar_high, bar_low, bar_price, is_close, input ready);
    modport sink   (input valid, bar_high, bar_low, bar_price, is_close, output ready);
endinterface

interface kdj_res_if;
    logic        valid;
    logic        ready;
    logic [22:0] k_value;
    logic [22:0] d_value;
    logic signed [25:0] j_value;
    logic        cross_up;
    logic        cross_down;
    logic        gap_over;
    logic        flat_range;
    modport source (output valid, k_value, d_value, j_value, cross_up, cross_down,
                    gap_over, flat_range, input ready);
    modport sink   (input valid, k_value, d_value, j_value, cross_up, cross_down,
                    gap_over, flat_range, output ready);
endinterface

interface kdj_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [22:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/kdj_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// KDJ controller
// Sequences window scan, RSV division, K/D update and result hand-off.
// ----------------------------------------------------------------------------
module kdj_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_out_busy,
    input  wire kdj_pkg::t_status i_status,
    output kdj_pkg::t_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DIV   = 6'b000100,
        S_K     = 6'b001000,
        S_D     = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_K;
            end
            S_K: begin
                o_cmd.k_calc = 1'b1;
                n_state = S_D;
            end
            S_D: begin
                o_cmd.d_calc = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/kdj_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// KDJ datapath
// Window ring, extreme scan, serial RSV divider, K/D/J and flags.
// ----------------------------------------------------------------------------
module kdj_dp #(
    parameter int unsigned WINDOW_LEN = 9,
    parameter int unsigned PRICE_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [PRICE_BITS-1:0] i_bar_high,
    input  wire logic [PRICE_BITS-1:0] i_bar_low,
    input  wire logic [PRICE_BITS-1:0] i_bar_price,
    input  wire logic                  i_is_close,
    input  wire logic                  i_cfg_we,
    input  wire kdj_pkg::t_reg_idx     i_cfg_idx,
    input  wire logic [22:0]           i_cfg_data,
    input  wire kdj_pkg::t_cmd         i_cmd,
    output kdj_pkg::t_status           o_status,
    output logic [22:0]                o_k,
    output logic [22:0]                o_d,
    output logic signed [25:0]         o_j,
    output logic                       o_cross_up,
    output logic                       o_cross_down,
    output logic                       o_gap_over,
    output logic                       o_flat
);

    localparam int unsigned DEPTH  = WINDOW_LEN - 1;
    localparam int unsigned PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW     = $clog2(DEPTH + 1);
    localparam int unsigned NUM_W  = PRICE_BITS + 23;
    localparam int unsigned DCW    = $clog2(NUM_W + 1);

    logic [PRICE_BITS-1:0] r_past_hi [DEPTH];
    logic [PRICE_BITS-1:0] r_past_lo [DEPTH];
    logic [PW-1:0]         r_wpos;
    logic [CW-1:0]         r_held;
    logic [22:0]           r_gap_thr;
    logic [22:0]           r_last_k, r_last_d;

    logic [PRICE_BITS-1:0] r_hi, r_lo, r_price, r_bhi, r_blo;
    logic                  r_close;
    logic [CW-1:0]         r_scan;
    logic [PRICE_BITS-1:0] r_rd_hi, r_rd_lo;
    logic                  r_rd_v;

    logic [NUM_W-1:0]      r_num;
    logic [PRICE_BITS-1:0] r_rem;
    logic [PRICE_BITS-1:0] r_den;
    logic [DCW-1:0]        r_dcnt;
    logic                  r_flat_i;
    logic [22:0]           r_rsv;
    logic [22:0]           r_k;

    logic [22:0]           w_cfg_sat;
    logic [PRICE_BITS-1:0] w_p;
    logic [PRICE_BITS:0]   w_rem_sh;
    logic [PRICE_BITS:0]   w_rem_sub;

    // floor(x / 3) for x below 2^25 by reciprocal multiply
    function automatic logic [22:0] div3(input logic [24:0] x);
        logic [48:0] v_prod;
        v_prod = 49'(x) * 49'(kdj_pkg::DIV3_MUL);
        return v_prod[47:25];
    endfunction

    assign w_cfg_sat = (i_cfg_data > kdj_pkg::Q_HUNDRED) ? kdj_pkg::Q_HUNDRED : i_cfg_data;

    // registers and committed K/D
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_thr <= '0;
            r_last_k  <= kdj_pkg::Q_FIFTY;
            r_last_d  <= kdj_pkg::Q_FIFTY;
            r_held    <= '0;
            r_wpos    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kdj_pkg::REG_K_START: begin
                        if (r_held == '0) r_last_k <= w_cfg_sat;
                    end
                    kdj_pkg::REG_D_START: begin
                        if (r_held == '0) r_last_d <= w_cfg_sat;
                    end
                    kdj_pkg::REG_GAP_THR: r_gap_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.finish && r_close) begin
                r_last_k <= o_k;
                r_last_d <= o_d;
                if (r_held != CW'(DEPTH)) r_held <= r_held + 1'b1;
                r_wpos <= (r_wpos == PW'(DEPTH - 1)) ? '0 : r_wpos + 1'b1;
            end
        end
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_close) begin
            r_past_hi[r_wpos] <= r_bhi;
            r_past_lo[r_wpos] <= r_blo;
        end
        r_rd_hi <= r_past_hi[r_scan[PW-1:0]];
        r_rd_lo <= r_past_lo[r_scan[PW-1:0]];
    end

    assign w_p = (r_price < r_lo) ? r_lo : ((r_price > r_hi) ? r_hi : r_price);
    assign w_rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_rd_v <= 1'b0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_scan <= '0;
                r_rd_v <= 1'b0;
            end else if (i_cmd.scan) begin
                if (r_scan != r_held) r_scan <= r_scan + 1'b1;
                r_rd_v <= (r_scan != r_held);
            end
            if (i_cmd.div_start) begin
                r_dcnt <= DCW'(NUM_W);
            end else if (i_cmd.div_step && r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_close <= i_is_close;
            r_price <= i_bar_price;
            r_bhi   <= i_bar_high;
            r_blo   <= i_bar_low;
            r_hi    <= i_is_close ? i_bar_high : i_bar_price;
            r_lo    <= i_is_close ? i_bar_low  : i_bar_price;
        end else if (i_cmd.scan && r_rd_v) begin
            if (r_rd_hi > r_hi) r_hi <= r_rd_hi;
            if (r_rd_lo < r_lo) r_lo <= r_rd_lo;
        end
        if (i_cmd.div_start) begin
            r_flat_i <= (r_hi <= r_lo);
            r_num    <= NUM_W'(w_p - r_lo) * NUM_W'(kdj_pkg::Q_HUNDRED);
            r_den    <= r_hi - r_lo;
            r_rem    <= '0;
        end else if (i_cmd.div_step && r_dcnt != '0) begin
            if (!w_rem_sub[PRICE_BITS]) begin
                r_rem <= w_rem_sub[PRICE_BITS-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[PRICE_BITS-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_step && r_dcnt == '0) begin
            r_rsv <= r_flat_i ? kdj_pkg::Q_FIFTY : r_num[22:0];
        end
        if (i_cmd.k_calc) begin
            r_k <= div3({1'b0, r_last_k, 1'b0} + 25'(r_rsv));
        end
        if (i_cmd.d_calc) begin
            o_k <= r_k;
            o_d <= div3({1'b0, r_last_d, 1'b0} + 25'(r_k));
        end
    end

    assign o_status.scan_done = i_cmd.scan && (r_scan == r_held) && !r_rd_v;
    assign o_status.div_done  = i_cmd.div_step && (r_dcnt == '0);

    assign o_j = 26'(signed'({3'b0, o_k}) * 26'sd3) - 26'(signed'({3'b0, o_d}) * 26'sd2);
    assign o_cross_up   = (r_last_d > r_last_k) && (o_d < o_k);
    assign o_cross_down = (r_last_d < r_last_k) && (o_d > o_k);
    assign o_gap_over   = ((o_k > o_d) ? (o_k - o_d) : (o_d - o_k)) > r_gap_thr;
    assign o_flat       = r_flat_i;

endmodule
`default_nettype wire

// ===== design/kdj_stochastic_oscillator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// KDJ stochastic oscillator
// Window extreme, RSV and K/D/J smoothing with crossing, gap and flat-range flags.
// ----------------------------------------------------------------------------
// channel  dir  word
// bar      in   bar_high, bar_low, bar_price, is_close
// res      out  k, d, j, cross_up, cross_down, gap_over, flat_range
// cfg      in   index, data
// From accept to the next accept, one bar goes through a scan of the bars held,
// the RSV divider, then K, D and the hand-off.
// Reset: synchronous active low; window contents undefined until written.
// Result register holds while the sink stalls; a next bar is computed, then waits in OUT.
// ----------------------------------------------------------------------------
module kdj_stochastic_oscillator #(
    parameter int unsigned WINDOW_LEN = 9,
    parameter int unsigned PRICE_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kdj_bar_if.sink   bar,
    kdj_res_if.source res,
    kdj_cfg_if.sink   cfg
);

    kdj_pkg::t_cmd    w_cmd;
    kdj_pkg::t_status w_status;
    logic             r_out_v;
    logic             w_in_ready;
    logic [22:0]      w_k, w_d;
    logic signed [25:0] w_j;
    logic             w_cu, w_cd, w_go, w_fl;

    assign cfg.ready = 1'b1;
    assign bar.ready = w_in_ready;

    kdj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (bar.valid),
        .o_in_ready (w_in_ready),
        .i_out_busy (r_out_v && !res.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    kdj_dp #(.WINDOW_LEN(WINDOW_LEN), .PRICE_BITS(PRICE_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bar_high   (bar.bar_high),
        .i_bar_low    (bar.bar_low),
        .i_bar_price  (bar.bar_price),
        .i_is_close   (bar.is_close),
        .i_cfg_we     (cfg.valid),
        .i_cfg_idx    (kdj_pkg::t_reg_idx'(cfg.index)),
        .i_cfg_data   (cfg.data),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_k          (w_k),
        .o_d          (w_d),
        .o_j          (w_j),
        .o_cross_up   (w_cu),
        .o_cross_down (w_cd),
        .o_gap_over   (w_go),
        .o_flat       (w_fl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_cmd.finish) begin
            r_out_v <= 1'b1;
        end else if (res.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.finish) begin
            res.k_value    <= w_k;
            res.d_value    <= w_d;
            res.j_value    <= w_j;
            res.cross_up   <= w_cu;
            res.cross_down <= w_cd;
            res.gap_over   <= w_go;
            res.flat_range <= w_fl;
        end
    end

    assign res.valid = r_out_v;

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> !(r_out_v && !res.ready))
        else $error("result overwritten");
    a_one_hot_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.scan, w_cmd.div_step, w_cmd.k_calc,
                  w_cmd.d_calc, w_cmd.finish}))
        else $error("overlapping commands");
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (bar.valid && w_in_ready))
        else $error("load without accept");
    a_valid_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> res.valid)
        else $error("result lost");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KDJ oscillator testbench
// Drives bars and register writes under random stalls and checks every
// result word against a cycle-free model of the K/D/J smoothing.
// ----------------------------------------------------------------------------

typedef struct {
    logic [22:0] k;
    logic [22:0] d;
    logic [25:0] j;
    logic        cu;
    logic        cd;
    logic        gap;
    logic        flat;
} t_kdj_word;

class kdj_scoreboard;
    logic [22:0] k_start, d_start, gap_thr, last_k, last_d;
    logic [23:0] highs[8];
    logic [23:0] lows[8];
    int          held, wpos, errors;
    t_kdj_word   pending[$];

    function new();
        k_start = kdj_pkg::Q_FIFTY;
        d_start = kdj_pkg::Q_FIFTY;
        gap_thr = '0;
        last_k  = kdj_pkg::Q_FIFTY;
        last_d  = kdj_pkg::Q_FIFTY;
        held    = 0;
        wpos    = 0;
        errors  = 0;
    endfunction

    function logic [22:0] clip_q100(logic [22:0] v);
        return (v > kdj_pkg::Q_HUNDRED) ? kdj_pkg::Q_HUNDRED : v;
    endfunction

    function void write_reg(kdj_pkg::t_reg_idx idx, logic [22:0] v);
        case (idx)
            kdj_pkg::REG_K_START: begin
                k_start = clip_q100(v);
                if (held == 0) last_k = k_start;
            end
            kdj_pkg::REG_D_START: begin
                d_start = clip_q100(v);
                if (held == 0) last_d = d_start;
            end
            kdj_pkg::REG_GAP_THR: gap_thr = v;
            default: ;
        endcase
    endfunction

    function void note_bar(logic [23:0] bh, logic [23:0] bl, logic [23:0] bp, logic cl);
        logic [23:0] hi, lo, p;
        longint      rsv, k, d, gap;
        t_kdj_word   w;
        hi = cl ? bh : bp;
        lo = cl ? bl : bp;
        for (int i = 0; i < held; i++) begin
            if (highs[i] > hi) hi = highs[i];
            if (lows[i] < lo) lo = lows[i];
        end
        w.flat = (hi <= lo);
        if (w.flat) begin
            rsv = kdj_pkg::Q_FIFTY;
        end else begin
            p = bp;
            if (p < lo) p = lo;
            if (p > hi) p = hi;
            rsv = (longint'(p - lo) * longint'(kdj_pkg::Q_HUNDRED)) / longint'(hi - lo);
        end
        k = (2 * longint'(last_k) + rsv) / 3;
        d = (2 * longint'(last_d) + k) / 3;
        gap = (k > d) ? k - d : d - k;
        w.k = k[22:0];
        w.d = d[22:0];
        w.j = 26'(3 * k - 2 * d);
        w.cu = (last_d > last_k) && (d < k);
        w.cd = (last_d < last_k) && (d > k);
        w.gap = gap > longint'(gap_thr);
        pending.push_back(w);
        if (cl) begin
            highs[wpos] = bh;
            lows[wpos]  = bl;
            wpos = (wpos + 1 >= 8) ? 0 : wpos + 1;
            if (held < 8) held++;
            last_k = w.k;
            last_d = w.d;
        end
    endfunction

    task report(string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_word(t_kdj_word got);
        t_kdj_word e;
        if (pending.size() == 0) begin
            report("result word with none pending");
            return;
        end
        e = pending.pop_front();
        if (got.k !== e.k) report($sformatf("k %0d exp %0d", got.k, e.k));
        if (got.d !== e.d) report($sformatf("d %0d exp %0d", got.d, e.d));
        if (got.j !== e.j) report($sformatf("j %0h exp %0h", got.j, e.j));
        if (got.cu !== e.cu) report("cross_up");
        if (got.cd !== e.cd) report("cross_down");
        if (got.gap !== e.gap) report("gap_over");
        if (got.flat !== e.flat) report("flat_range");
    endtask
endclass

module tb_top;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycles = 0;
    bit     calm = 0;

    kdj_bar_if #(.PRICE_BITS(24)) bar();
    kdj_res_if res();
    kdj_cfg_if cfg();

    kdj_stochastic_oscillator #(.WINDOW_LEN(9), .PRICE_BITS(24)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .bar(bar), .res(res), .cfg(cfg)
    );

    kdj_scoreboard sb = new();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        bar.valid = 1'b0; bar.bar_high = '0; bar.bar_low = '0;
        bar.bar_price = '0; bar.is_close = 1'b0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        res.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result sink with random stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_kdj_word got;
        if (i_rst_n && res.valid && res.ready) begin
            got.k = res.k_value; got.d = res.d_value; got.j = res.j_value;
            got.cu = res.cross_up; got.cd = res.cross_down;
            got.gap = res.gap_over; got.flat = res.flat_range;
            sb.check_word(got);
        end
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 17);
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
    endtask

    task automatic send_bar(logic [23:0] bh, logic [23:0] bl, logic [23:0] bp, logic cl);
        idle_gap();
        bar.valid <= 1'b1;
        bar.bar_high <= bh; bar.bar_low <= bl; bar.bar_price <= bp; bar.is_close <= cl;
        do @(posedge i_clk); while (!bar.ready);
        sb.note_bar(bh, bl, bp, cl);
        bar.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(kdj_pkg::t_reg_idx idx, logic [22:0] v);
        cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= v;
        do @(posedge i_clk); while (!cfg.ready);
        sb.write_reg(idx, v);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_bar();
        logic [23:0] a, b, p;
        int mode;
        mode = $urandom_range(0, 9);
        a = 24'($urandom); b = 24'($urandom); p = 24'($urandom);
        if (mode < 6) begin
            a = 24'(24'd1000000 + $urandom_range(0, 4000));
            b = 24'(a - $urandom_range(0, 3000));
            p = 24'(b + $urandom_range(0, 3500) - 200);
        end else if (mode == 6) begin
            b = a;
            p = a;
        end
        send_bar(a, b, p, $urandom_range(0, 3) != 0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // start values while no bar is committed, including saturation
        write_reg(kdj_pkg::REG_K_START, 23'h7FFFFF);
        write_reg(kdj_pkg::REG_D_START, 23'd0);
        write_reg(kdj_pkg::REG_GAP_THR, 23'd6553600);
        write_reg(kdj_pkg::REG_NONE, 23'h555555);
        send_bar(24'hFFFFFF, 24'd0, 24'hFFFFFF, 1'b1);
        send_bar(24'd0, 24'hFFFFFF, 24'd5, 1'b1);
        send_bar(24'd100, 24'd100, 24'd100, 1'b0);
        send_bar(24'd200, 24'd10, 24'hFFFFFF, 1'b0);
        send_bar(24'd200, 24'd10, 24'd0, 1'b1);
        send_bar(24'd50, 24'd50, 24'd50, 1'b1);
        for (int i = 0; i < 10; i++)
            send_bar(24'(1000 + i * 7), 24'(900 - i), 24'(950 + i * 3), 1'b1);
        send_bar(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_bar(24'hAAAAAA, 24'h555555, 24'h800000, 1'b0);
        drain();
        // late start write: held only, no load
        write_reg(kdj_pkg::REG_K_START, 23'd0);
        write_reg(kdj_pkg::REG_GAP_THR, 23'd0);
        for (int n = 0; n < 2000; n++) begin
            if (n == 700) begin
                drain();
                write_reg(kdj_pkg::REG_GAP_THR, 23'($urandom_range(0, 6553600)));
                write_reg(kdj_pkg::REG_D_START, 23'($urandom));
            end
            if (n == 1400) begin
                drain();
                write_reg(kdj_pkg::REG_GAP_THR, 23'h7FFFFF);
                calm = 1;
            end
            random_bar();
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
